[sv/swrl_pkg.sv]
// ----------------------------------------------------------------------------
// swrl_pkg: shared types and constants of the sliding window rate limiter
// Holds register codes, reset values, field widths and the cell command type.
// ----------------------------------------------------------------------------
package swrl_pkg;

	// Default geometry of the time stamp chain.
	localparam int RING_DEPTH_DEF = 64;
	localparam int TIME_BITS_DEF  = 32;

	// Field widths fixed by the register and result formats.
	localparam int MAX_ADM_W   = 7;
	localparam int WINDOW_W    = 31;
	localparam int HELD_W      = 7;
	localparam int CFG_DATA_W  = 31;
	localparam int CFG_INDEX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_ADMITTED  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 1'b1;

	// Register reset values.
	localparam logic [MAX_ADM_W-1:0] MAX_ADMITTED_RESET  = 7'd5;
	localparam logic [WINDOW_W-1:0]  WINDOW_LENGTH_RESET = 31'd1000;

	// Command broadcast from the controller to every cell of the chain.
	typedef struct packed {
		logic shift;  // every cell takes its upper neighbor's stamp, the last cell the current time
		logic load;   // the cell addressed by the fill count takes the new stamp
	} chain_cmd_t;

endpackage

[sv/swrl_cell.sv]
// ----------------------------------------------------------------------------
// swrl_cell: one slot of the time stamp chain
// Holds one stored arrival time; shifts toward the oldest end or loads a new one.
// ----------------------------------------------------------------------------
module swrl_cell
	import swrl_pkg::*;
#(
	parameter int INDEX     = 0,
	parameter int CNT_W     = 7,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  chain_cmd_t           cmd,
	input  logic [CNT_W-1:0]     slot,
	input  logic [TIME_BITS-1:0] new_stamp,
	input  logic [TIME_BITS-1:0] next_stamp,
	output logic [TIME_BITS-1:0] stamp
);

	logic [TIME_BITS-1:0] stamp_q;

	// The fill count points at the first free slot, which takes the new stamp.
	always_ff @(posedge clk) begin
		if (cmd.load && (slot == CNT_W'(INDEX))) begin
			stamp_q <= new_stamp;
		end else if (cmd.shift) begin
			stamp_q <= next_stamp;
		end
	end

	assign stamp = stamp_q;

endmodule

[sv/swrl_ctrl.sv]
// ----------------------------------------------------------------------------
// swrl_ctrl: sequencer of the sliding window rate limiter
// Expires old stamps at the chain head, decides admission, holds the result.
// ----------------------------------------------------------------------------
module swrl_ctrl
	import swrl_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF,
	parameter int CNT_W      = $clog2(RING_DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [TIME_BITS-1:0]   in_time,
	input  logic [TIME_BITS-1:0]   head_stamp,
	output chain_cmd_t             cmd,
	output logic [CNT_W-1:0]       fill,
	output logic [TIME_BITS-1:0]   now,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   out_admitted,
	output logic [HELD_W-1:0]      out_held
);

	localparam int CMP_W = ((CNT_W > MAX_ADM_W) ? CNT_W : MAX_ADM_W) + 1;
	localparam int AGE_W = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EXPIRE = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;

	logic [1:0]           state_q;
	logic [CNT_W-1:0]     count_q;
	logic [MAX_ADM_W-1:0] max_adm_q;
	logic [WINDOW_W-1:0]  window_q;
	logic                 out_valid_q;
	logic [TIME_BITS-1:0] now_q;
	logic                 adm_q;
	logic [HELD_W-1:0]    held_q;

	logic [TIME_BITS-1:0] age;
	logic                 expired;
	logic [CMP_W-1:0]     max_ext;
	logic [CMP_W-1:0]     limit;
	logic                 room;
	logic                 out_free;
	logic [CNT_W-1:0]     count_next;

	// Age is taken modulo the time width, then compared unsigned to the window.
	assign age     = now_q - head_stamp;
	assign expired = AGE_W'(age) > AGE_W'(window_q);

	// A limit above the chain length saturates to the chain length.
	assign max_ext = CMP_W'(max_adm_q);
	assign limit   = (max_ext > CMP_W'(RING_DEPTH)) ? CMP_W'(RING_DEPTH) : max_ext;
	assign room    = CMP_W'(count_q) < limit;

	assign out_free   = !out_valid_q || out_ready;
	assign count_next = room ? (count_q + 1'b1) : count_q;

	always_comb begin
		cmd.shift = (state_q == ST_EXPIRE) && (count_q != '0) && expired;
		cmd.load  = (state_q == ST_DECIDE) && out_free && room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			max_adm_q   <= MAX_ADMITTED_RESET;
			window_q    <= WINDOW_LENGTH_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAX_ADMITTED:  max_adm_q <= cfg_data[MAX_ADM_W-1:0];
					REG_WINDOW_LENGTH: window_q  <= cfg_data[WINDOW_W-1:0];
				endcase
			end
			// A new result replaces the one being taken in the same cycle.
			if ((state_q == ST_DECIDE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXPIRE;
					end
				end
				ST_EXPIRE: begin
					if (cmd.shift) begin
						count_q <= count_q - 1'b1;
					end else begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (out_free) begin
						count_q <= count_next;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			now_q <= in_time;
		end
		if ((state_q == ST_DECIDE) && out_free) begin
			adm_q  <= room;
			held_q <= HELD_W'(count_next);
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign fill         = count_q;
	assign now          = now_q;
	assign out_valid    = out_valid_q;
	assign out_admitted = adm_q;
	assign out_held     = held_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= RING_DEPTH)
		else $error("stored count exceeds chain length");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.shift && cmd.load))
		else $error("shift and load issued together");

	a_load_counts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> count_q == $past(count_q) + 1'b1)
		else $error("load did not advance the count");

	a_shift_counts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |=> count_q == $past(count_q) - 1'b1)
		else $error("shift did not retire one stamp");

	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) && out_free |=> (state_q == ST_IDLE) && out_valid_q)
		else $error("decision did not produce a result");
`endif

endmodule

[sv/sliding_window_rate_limiter_core.sv]
// Sequence: a request word is taken in the idle state; stamps that have left the window
//   then expire, the head cell's age compare retiring one stamp a cycle, and the decide
//   state registers the result, waiting until the last one is taken; only idle takes requests.
// Reset: arst_n clears the sequencer, the stored count and the output valid at once and loads
//   max_admitted = 5, window_length = 1000; stamp cells are not cleared and need no pass.
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter_core: sliding window log rate limiter
// Keeps the arrival times of admitted requests in a chain of cells and admits a
// request while fewer than max_admitted of them lie inside the window.
// ----------------------------------------------------------------------------
module sliding_window_rate_limiter_core
	import swrl_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration writes: index 0 is max_admitted, index 1 is window_length.
	input  logic                                cfg_we,
	input  logic [CFG_INDEX_W-1:0]              cfg_index,
	input  logic [CFG_DATA_W-1:0]               cfg_data,
	// Request words.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((TIME_BITS + 7) / 8) * 8-1:0] s_tdata,  // arrival_time, zero padded
	// Result words.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [7:0]                          m_tdata   // held_count[6:0], admitted
);

	localparam int CNT_W = $clog2(RING_DEPTH + 1);

	chain_cmd_t           cmd;
	logic [CNT_W-1:0]     fill;
	logic [TIME_BITS-1:0] now;
	logic                 admitted;
	logic [HELD_W-1:0]    held_count;
	logic [TIME_BITS-1:0] stamps [RING_DEPTH];
	logic [TIME_BITS-1:0] nexts  [RING_DEPTH];

	// The sequencer checks only the head cell, so one stamp expires per cycle and the
	// admission test is a compare of the fill count against the saturated limit.
	swrl_ctrl #(
		.RING_DEPTH (RING_DEPTH),
		.TIME_BITS  (TIME_BITS),
		.CNT_W      (CNT_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_time      (s_tdata[TIME_BITS-1:0]),
		.head_stamp   (stamps[0]),
		.cmd          (cmd),
		.fill         (fill),
		.now          (now),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_admitted (admitted),
		.out_held     (held_count)
	);

	// Cell 0 always holds the oldest stamp. A shift moves every stamp one cell toward
	// the head; a load writes the new stamp into the first free cell.
	for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
		if (i == RING_DEPTH - 1) begin : g_last
			assign nexts[i] = now;
		end else begin : g_mid
			assign nexts[i] = stamps[i+1];
		end

		swrl_cell #(
			.INDEX     (i),
			.CNT_W     (CNT_W),
			.TIME_BITS (TIME_BITS)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.slot       (fill),
			.new_stamp  (now),
			.next_stamp (nexts[i]),
			.stamp      (stamps[i])
		);
	end

	assign m_tdata = {held_count, admitted};

endmodule
